// ===== hdl/rvenc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvenc_pkg
// Opcodes, mnemonic indexes, error codes and shared types of the RV32I
// instruction encoder.
// ----------------------------------------------------------------------------
package rvenc_pkg;

	// major opcodes
	localparam logic [6:0] OP_REG   = 7'b0110011;
	localparam logic [6:0] OP_IMM   = 7'b0010011;
	localparam logic [6:0] OP_STORE = 7'b0100011;
	localparam logic [6:0] OP_LOAD  = 7'b0000011;
	localparam logic [6:0] OP_BR    = 7'b1100011;
	localparam logic [6:0] OP_LUI   = 7'b0110111;
	localparam logic [6:0] OP_AUIPC = 7'b0010111;
	localparam logic [6:0] OP_JAL   = 7'b1101111;
	localparam logic [6:0] OP_JALR  = 7'b1100111;
	localparam logic [6:0] OP_SYS   = 7'b1110011;
	localparam logic [6:0] F7_ALT   = 7'b0100000;
	localparam logic [31:0] HI_MASK = 32'hFFFFF000;

	// mnemonic indexes
	localparam logic [5:0] MN_ADDI  = 6'd0;
	localparam logic [5:0] MN_SLTI  = 6'd1;
	localparam logic [5:0] MN_SLTIU = 6'd2;
	localparam logic [5:0] MN_ANDI  = 6'd3;
	localparam logic [5:0] MN_ORI   = 6'd4;
	localparam logic [5:0] MN_XORI  = 6'd5;
	localparam logic [5:0] MN_SLLI  = 6'd6;
	localparam logic [5:0] MN_SRLI  = 6'd7;
	localparam logic [5:0] MN_SRAI  = 6'd8;
	localparam logic [5:0] MN_ADD   = 6'd9;
	localparam logic [5:0] MN_SUB   = 6'd10;
	localparam logic [5:0] MN_SLT   = 6'd11;
	localparam logic [5:0] MN_SLTU  = 6'd12;
	localparam logic [5:0] MN_AND   = 6'd13;
	localparam logic [5:0] MN_OR    = 6'd14;
	localparam logic [5:0] MN_XOR   = 6'd15;
	localparam logic [5:0] MN_SLL   = 6'd16;
	localparam logic [5:0] MN_SRL   = 6'd17;
	localparam logic [5:0] MN_SRA   = 6'd18;
	localparam logic [5:0] MN_LB    = 6'd19;
	localparam logic [5:0] MN_LH    = 6'd20;
	localparam logic [5:0] MN_LW    = 6'd21;
	localparam logic [5:0] MN_LBU   = 6'd22;
	localparam logic [5:0] MN_LHU   = 6'd23;
	localparam logic [5:0] MN_SB    = 6'd24;
	localparam logic [5:0] MN_SH    = 6'd25;
	localparam logic [5:0] MN_SW    = 6'd26;
	localparam logic [5:0] MN_BEQ   = 6'd27;
	localparam logic [5:0] MN_BNE   = 6'd28;
	localparam logic [5:0] MN_BLT   = 6'd29;
	localparam logic [5:0] MN_BLTU  = 6'd30;
	localparam logic [5:0] MN_BGE   = 6'd31;
	localparam logic [5:0] MN_BGEU  = 6'd32;
	localparam logic [5:0] MN_JAL   = 6'd33;
	localparam logic [5:0] MN_JALR  = 6'd34;
	localparam logic [5:0] MN_LUI   = 6'd35;
	localparam logic [5:0] MN_AUIPC = 6'd36;
	localparam logic [5:0] MN_ECALL = 6'd37;
	localparam logic [5:0] MN_LA    = 6'd38;
	localparam logic [5:0] MN_LI    = 6'd39;
	localparam logic [5:0] MN_CALL  = 6'd40;

	// error codes
	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_UNKNOWN = 3'd1;
	localparam logic [2:0] ERR_COUNT   = 3'd2;
	localparam logic [2:0] ERR_RANGE   = 3'd3;
	localparam logic [2:0] ERR_ODD     = 3'd4;
	localparam logic [2:0] ERR_SHIFT   = 3'd5;

	localparam logic [4:0] REG_RA = 5'd1;

	typedef struct packed {
		logic [5:0]  mnemonic;
		logic [4:0]  dest_reg;
		logic [4:0]  src1_reg;
		logic [4:0]  src2_reg;
		logic [31:0] imm_value;
		logic        imm_is_label;
		logic [1:0]  operand_count;
	} item_t;

	typedef struct packed {
		logic [31:0] first_word;
		logic [31:0] second_word;
		logic        two_words;
		logic [2:0]  error_code;
	} enc_t;

	function automatic logic [2:0] funct3_of(input logic [5:0] mn);
		logic [2:0] f3;
		f3 = 3'd0;
		case (mn)
			MN_SLTI, MN_SLT, MN_LW, MN_SW:                 f3 = 3'd2;
			MN_SLTIU, MN_SLTU:                             f3 = 3'd3;
			MN_ANDI, MN_AND, MN_BGEU:                      f3 = 3'd7;
			MN_ORI, MN_OR, MN_BLTU:                        f3 = 3'd6;
			MN_XORI, MN_XOR, MN_LBU, MN_BLT:               f3 = 3'd4;
			MN_SLLI, MN_SLL, MN_LH, MN_SH, MN_BNE:         f3 = 3'd1;
			MN_SRLI, MN_SRAI, MN_SRL, MN_SRA, MN_LHU,
			MN_BGE:                                        f3 = 3'd5;
			default:                                       f3 = 3'd0;
		endcase
		return f3;
	endfunction

endpackage

// ===== hdl/rvenc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvenc_in_if
// Valid/ready channel carrying one parsed assembly item.
// ----------------------------------------------------------------------------
interface rvenc_in_if;
	logic        valid;
	logic        ready;
	logic [5:0]  mnemonic;
	logic [4:0]  dest_reg;
	logic [4:0]  src1_reg;
	logic [4:0]  src2_reg;
	logic signed [31:0] imm_value;
	logic        imm_is_label;
	logic [1:0]  operand_count;

	modport source (
		output valid, mnemonic, dest_reg, src1_reg, src2_reg, imm_value,
		output imm_is_label, operand_count,
		input  ready
	);
	modport sink (
		input  valid, mnemonic, dest_reg, src1_reg, src2_reg, imm_value,
		input  imm_is_label, operand_count,
		output ready
	);
endinterface

// ===== hdl/rvenc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvenc_out_if
// Valid/ready channel carrying one machine word with its status.
// ----------------------------------------------------------------------------
interface rvenc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] code_word;
	logic [2:0]  error_code;
	logic        last_word;

	modport source (
		output valid, code_word, error_code, last_word,
		input  ready
	);
	modport sink (
		input  valid, code_word, error_code, last_word,
		output ready
	);
endinterface

// ===== hdl/rvenc_encode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvenc_encode
// Operand checks and field packing for one item against the current PC.
// ----------------------------------------------------------------------------
module rvenc_encode (
	input  rvenc_pkg::item_t item,
	input  logic [31:0]      pc,
	output rvenc_pkg::enc_t  enc
);
	import rvenc_pkg::*;

	logic [31:0] imm;
	logic [31:0] rel;
	logic [31:0] off;
	logic [31:0] pv;
	logic [19:0] hi;
	logic [11:0] imm12;
	logic [2:0]  f3;
	logic        fits12;
	logic        fits13;
	logic        fits21;
	logic        fits20;
	logic        is_jump_br;

	always_comb begin
		imm        = item.imm_value;
		rel        = imm - pc;
		is_jump_br = (item.mnemonic >= MN_BEQ) && (item.mnemonic <= MN_JAL);
		off        = (item.imm_is_label && is_jump_br) ? rel : imm;
		pv         = (item.mnemonic == MN_LI) ? imm : rel;
		// round the upper part up when the low part is negative
		hi         = pv[31:12] + {19'd0, pv[11]};
		f3         = funct3_of(item.mnemonic);
		fits12     = (&imm[31:12]) || ~(|imm[31:12]);
		fits20     = (&imm[31:20]) || ~(|imm[31:20]);
		fits13     = (&off[31:13]) || ~(|off[31:13]);
		fits21     = (&off[31:21]) || ~(|off[31:21]);
		imm12      = imm[11:0] | ((item.mnemonic == MN_SRAI) ? {F7_ALT, 5'd0} : 12'd0);
	end

	always_comb begin
		enc.first_word  = '0;
		enc.second_word = '0;
		enc.two_words   = 1'b0;
		enc.error_code  = ERR_NONE;
		unique case (item.mnemonic) inside
			[MN_ADDI:MN_SRAI]: begin
				if (item.operand_count != 2'd3) begin
					enc.error_code = ERR_COUNT;
				end else if (item.mnemonic >= MN_SLLI && |imm[31:5]) begin
					enc.error_code = ERR_SHIFT;
				end else if (!fits12) begin
					enc.error_code = ERR_RANGE;
				end else begin
					enc.first_word = {imm12, item.src1_reg, f3, item.dest_reg, OP_IMM};
				end
			end
			[MN_ADD:MN_SRA]: begin
				if (item.operand_count != 2'd3) begin
					enc.error_code = ERR_COUNT;
				end else begin
					enc.first_word = {
						(item.mnemonic == MN_SUB || item.mnemonic == MN_SRA) ? F7_ALT : 7'd0,
						item.src2_reg, item.src1_reg, f3, item.dest_reg, OP_REG};
				end
			end
			[MN_LB:MN_LHU], MN_JALR: begin
				if (item.operand_count != 2'd3) begin
					enc.error_code = ERR_COUNT;
				end else if (!fits12) begin
					enc.error_code = ERR_RANGE;
				end else begin
					enc.first_word = {imm[11:0], item.src1_reg, f3, item.dest_reg,
						(item.mnemonic == MN_JALR) ? OP_JALR : OP_LOAD};
				end
			end
			[MN_SB:MN_SW]: begin
				if (item.operand_count != 2'd3) begin
					enc.error_code = ERR_COUNT;
				end else if (!fits12) begin
					enc.error_code = ERR_RANGE;
				end else begin
					enc.first_word = {imm[11:5], item.dest_reg, item.src1_reg, f3,
						imm[4:0], OP_STORE};
				end
			end
			[MN_BEQ:MN_BGEU]: begin
				if (item.operand_count != 2'd3) begin
					enc.error_code = ERR_COUNT;
				end else if (!fits13) begin
					enc.error_code = ERR_RANGE;
				end else if (off[0]) begin
					enc.error_code = ERR_ODD;
				end else begin
					enc.first_word = {off[12], off[10:5], item.src2_reg, item.src1_reg, f3,
						off[4:1], off[11], OP_BR};
				end
			end
			MN_JAL: begin
				if (item.operand_count != 2'd2) begin
					enc.error_code = ERR_COUNT;
				end else if (!fits21) begin
					enc.error_code = ERR_RANGE;
				end else if (off[0]) begin
					enc.error_code = ERR_ODD;
				end else begin
					enc.first_word = {off[20], off[10:1], off[11], off[19:12],
						item.dest_reg, OP_JAL};
				end
			end
			MN_LUI, MN_AUIPC: begin
				if (item.operand_count != 2'd2) begin
					enc.error_code = ERR_COUNT;
				end else if (!fits20) begin
					enc.error_code = ERR_RANGE;
				end else begin
					enc.first_word = {imm[19:0], item.dest_reg,
						(item.mnemonic == MN_LUI) ? OP_LUI : OP_AUIPC};
				end
			end
			MN_ECALL: begin
				if (item.operand_count != 2'd0) begin
					enc.error_code = ERR_COUNT;
				end else begin
					enc.first_word = {25'd0, OP_SYS};
				end
			end
			MN_LA, MN_LI: begin
				if (item.operand_count != 2'd2) begin
					enc.error_code = ERR_COUNT;
				end else begin
					enc.two_words   = 1'b1;
					enc.first_word  = {hi, item.dest_reg,
						(item.mnemonic == MN_LI) ? OP_LUI : OP_AUIPC};
					enc.second_word = {pv[11:0], item.dest_reg, 3'd0, item.dest_reg, OP_IMM};
				end
			end
			MN_CALL: begin
				if (item.operand_count != 2'd1) begin
					enc.error_code = ERR_COUNT;
				end else begin
					enc.two_words   = 1'b1;
					enc.first_word  = {hi, REG_RA, OP_AUIPC};
					enc.second_word = {pv[11:0], REG_RA, 3'd0, REG_RA, OP_JALR};
				end
			end
			default: begin
				enc.error_code = ERR_UNKNOWN;
			end
		endcase
	end

endmodule

// ===== hdl/rv32i_instruction_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_instruction_encoder
// Turns parsed RV32I assembly items into machine words, tracking the PC.
// ----------------------------------------------------------------------------
// An item is registered on acceptance, encoded combinationally from that
// register and its word lands in the output register once that is free.
// Real instructions and errors give one result beat; la, li and call give two
// beats (last_word low, then high) and hold the input register until both
// words are emitted, since the result channel moves one word per beat.
// The PC starts at zero after reset and steps by 4 or 8 only on success.
module rv32i_instruction_encoder (
	input  logic           clk,
	input  logic           arst_n,
	rvenc_in_if.sink       instr,
	rvenc_out_if.source    code
);
	import rvenc_pkg::*;

	localparam logic [31:0] PC_STEP_ONE = 32'd4;
	localparam logic [31:0] PC_STEP_TWO = 32'd8;

	item_t       item_s1;
	logic        valid_s1;
	logic        phase_q;
	logic [31:0] pc_q;
	enc_t        enc;
	logic        s1_emit;
	logic        s1_done;
	logic        in_take;
	logic        out_valid_q;
	logic [31:0] code_word_q;
	logic [2:0]  error_code_q;
	logic        last_word_q;

	rvenc_encode u_encode (
		.item (item_s1),
		.pc   (pc_q),
		.enc  (enc)
	);

	assign s1_emit     = valid_s1 && (!out_valid_q || code.ready);
	assign s1_done     = s1_emit && (phase_q || !enc.two_words);
	assign instr.ready = !valid_s1 || s1_done;
	assign in_take     = instr.valid && instr.ready;

	assign code.valid      = out_valid_q;
	assign code.code_word  = code_word_q;
	assign code.error_code = error_code_q;
	assign code.last_word  = last_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= 1'b0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			// phase marks that the first word of a pseudo has gone out
			if (s1_emit) begin
				phase_q <= !s1_done;
			end
			if (s1_done && enc.error_code == ERR_NONE) begin
				pc_q <= pc_q + (enc.two_words ? PC_STEP_TWO : PC_STEP_ONE);
			end
			if (s1_emit) begin
				out_valid_q <= 1'b1;
			end else if (code.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.mnemonic      <= instr.mnemonic;
			item_s1.dest_reg      <= instr.dest_reg;
			item_s1.src1_reg      <= instr.src1_reg;
			item_s1.src2_reg      <= instr.src2_reg;
			item_s1.imm_value     <= instr.imm_value;
			item_s1.imm_is_label  <= instr.imm_is_label;
			item_s1.operand_count <= instr.operand_count;
		end
		if (s1_emit) begin
			code_word_q  <= phase_q ? enc.second_word : enc.first_word;
			error_code_q <= enc.error_code;
			last_word_q  <= phase_q || !enc.two_words;
		end
	end

endmodule

// ===== hdl/rvenc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvenc_checker
// Port-level checks of the encoder result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rvenc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] code_word,
	input logic [2:0]  error_code,
	input logic        last_word
);
	import rvenc_pkg::*;

	// a stalled beat keeps its word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_word) && $stable(last_word))
		else $error("result beat changed while stalled");

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> code_word == '0 && last_word)
		else $error("error beat must be a lone zero word");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code <= ERR_SHIFT)
		else $error("error code out of range");

	// first half of a pseudo is always an upper-immediate instruction
	a_first_half: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_word |->
			error_code == ERR_NONE &&
			(code_word[6:0] == OP_AUIPC || code_word[6:0] == OP_LUI))
		else $error("non-final beat is not auipc or lui");

	// second half of a pseudo follows at once when the first is taken
	a_second_half: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=> out_valid && last_word)
		else $error("second word of a pseudo did not follow");

endmodule

bind rv32i_instruction_encoder rvenc_checker u_rvenc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (code.valid),
	.out_ready  (code.ready),
	.code_word  (code.code_word),
	.error_code (code.error_code),
	.last_word  (code.last_word)
);
